FILE: sv/bst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the byte stream tokenizer.
// No dependencies; imported by bst_lexer, bst_res_fifo and byte_stream_tokenizer.
package bst_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int RES_DEPTH       = 4;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DOT    = 8'h2E;

	typedef enum logic [3:0] {
		KIND_SYMBOL = 4'd0,
		KIND_EQ     = 4'd1,
		KIND_EQEQ   = 4'd2,
		KIND_DCOLON = 4'd3,
		KIND_PLUS   = 4'd4,
		KIND_STRING = 4'd5,
		KIND_LPAREN = 4'd6,
		KIND_RPAREN = 4'd7,
		KIND_LBRACE = 4'd8,
		KIND_RBRACE = 4'd9,
		KIND_COMMA  = 4'd10,
		KIND_SEMI   = 4'd11,
		KIND_DOT    = 4'd12
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_UNTERM  = 2'd1,
		ERR_COLON   = 2'd2
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
		err_t        err;
		logic        last;
	} res_t;

	// Results produced by one accepted byte, in order
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

FILE: sv/bst_lexer.sv
`timescale 1ns / 1ps
// Tokenizer state and per-byte decode: mode, pending token and byte offset.
// Depends on bst_pkg; produces up to two results per accepted byte.
module bst_lexer
	import bst_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_byte,
	input  logic       end_of_text,
	output push_t      push
);

	typedef logic [OFFSET_BITS-1:0] off_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_SYMBOL = 3'd1,
		MODE_EQ     = 3'd2,
		MODE_COLON  = 3'd3,
		MODE_STRING = 3'd4,
		MODE_ERROR  = 3'd5
	} mode_t;

	typedef struct packed {
		logic  v;
		kind_t kind;
		off_t  start;
		off_t  len;
		err_t  err;
	} emit_t;

	localparam off_t OFF_MAX = {OFFSET_BITS{1'b1}};
	localparam off_t OFF_ONE = OFFSET_BITS'(1);
	localparam off_t OFF_TWO = OFFSET_BITS'(2);

	mode_t mode_q, mode_d;
	off_t  ps_q, ps_d;
	off_t  pl_q, pl_d;
	off_t  bp_q, bp_d;

	emit_t ea, eb, ec;
	logic  begin_now;
	logic  is_space, is_single, is_sym;
	kind_t single_kind;
	emit_t first, second;

	function automatic off_t sat_inc(input off_t v);
		return (v == OFF_MAX) ? OFF_MAX : v + OFF_ONE;
	endfunction

	function automatic logic [15:0] to16(input off_t v);
		logic [47:0] w;
		w = 48'(v);
		return w[15:0];
	endfunction

	function automatic res_t to_res(input emit_t e, input logic last);
		res_t r;
		r.kind   = e.kind;
		r.start  = to16(e.start);
		r.length = to16(e.len);
		r.err    = e.err;
		r.last   = last;
		return r;
	endfunction

	always_comb begin
		is_single   = 1'b1;
		single_kind = KIND_SYMBOL;
		case (char_byte)
			CH_PLUS:   single_kind = KIND_PLUS;
			CH_LPAREN: single_kind = KIND_LPAREN;
			CH_RPAREN: single_kind = KIND_RPAREN;
			CH_LBRACE: single_kind = KIND_LBRACE;
			CH_RBRACE: single_kind = KIND_RBRACE;
			CH_COMMA:  single_kind = KIND_COMMA;
			CH_SEMI:   single_kind = KIND_SEMI;
			CH_DOT:    single_kind = KIND_DOT;
			default:   is_single = 1'b0;
		endcase
		is_space = char_byte inside {CH_SPACE, CH_NL};
		is_sym   = !is_space && !is_single &&
			!(char_byte inside {CH_QUOTE, CH_EQ, CH_COLON});
	end

	always_comb begin
		mode_d    = mode_q;
		ps_d      = ps_q;
		pl_d      = pl_q;
		bp_d      = sat_inc(bp_q);
		ea        = '0;
		eb        = '0;
		ec        = '0;
		begin_now = 1'b0;

		case (mode_q)
			MODE_SYMBOL: begin
				if (is_sym) begin
					pl_d = sat_inc(pl_q);
				end else begin
					ea = '{1'b1, KIND_SYMBOL, ps_q, pl_q, ERR_NONE};
					begin_now = 1'b1;
				end
			end
			MODE_EQ: begin
				if (char_byte == CH_EQ) begin
					ea = '{1'b1, KIND_EQEQ, ps_q, OFF_TWO, ERR_NONE};
					mode_d = MODE_IDLE;
				end else begin
					ea = '{1'b1, KIND_EQ, ps_q, OFF_ONE, ERR_NONE};
					begin_now = 1'b1;
				end
			end
			MODE_COLON: begin
				if (char_byte == CH_COLON) begin
					ea = '{1'b1, KIND_DCOLON, ps_q, OFF_TWO, ERR_NONE};
					mode_d = MODE_IDLE;
				end else begin
					// lone colon: drop this byte and discard until end of text
					ea = '{1'b1, KIND_SYMBOL, ps_q, OFF_ONE, ERR_COLON};
					mode_d = MODE_ERROR;
				end
			end
			MODE_STRING: begin
				pl_d = sat_inc(pl_q);
				if (char_byte == CH_QUOTE) begin
					ea = '{1'b1, KIND_STRING, ps_q, pl_d, ERR_NONE};
					mode_d = MODE_IDLE;
				end
			end
			MODE_ERROR: begin
				mode_d = MODE_ERROR;
			end
			default: begin
				begin_now = 1'b1;
			end
		endcase

		if (begin_now) begin
			mode_d = MODE_IDLE;
			ps_d   = bp_q;
			pl_d   = OFF_ONE;
			if (is_space) begin
				ps_d = '0;
				pl_d = '0;
			end else if (char_byte == CH_QUOTE) begin
				mode_d = MODE_STRING;
			end else if (char_byte == CH_EQ) begin
				mode_d = MODE_EQ;
			end else if (char_byte == CH_COLON) begin
				mode_d = MODE_COLON;
			end else if (is_single) begin
				eb = '{1'b1, single_kind, bp_q, OFF_ONE, ERR_NONE};
			end else begin
				mode_d = MODE_SYMBOL;
			end
		end

		// close whatever is pending and restart offsets for the next text
		if (end_of_text) begin
			case (mode_d)
				MODE_SYMBOL: ec = '{1'b1, KIND_SYMBOL, ps_d, pl_d, ERR_NONE};
				MODE_EQ:     ec = '{1'b1, KIND_EQ, ps_d, OFF_ONE, ERR_NONE};
				MODE_COLON:  ec = '{1'b1, KIND_SYMBOL, ps_d, OFF_ONE, ERR_COLON};
				MODE_STRING: ec = '{1'b1, KIND_SYMBOL, ps_d, pl_d, ERR_UNTERM};
				default:     ec = '0;
			endcase
			mode_d = MODE_IDLE;
			ps_d   = '0;
			pl_d   = '0;
			bp_d   = '0;
		end
	end

	// at most two of the three emit points fire for one byte
	always_comb begin
		first  = ea.v ? ea : (eb.v ? eb : ec);
		second = ea.v ? (eb.v ? eb : ec) : ec;
		push.count = step ? (2'(ea.v) + 2'(eb.v) + 2'(ec.v)) : 2'd0;
		push.r0    = to_res(first, push.count == 2'd1);
		push.r1    = to_res(second, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			ps_q   <= '0;
			pl_q   <= '0;
			bp_q   <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			ps_q   <= ps_d;
			pl_q   <= pl_d;
			bp_q   <= bp_d;
		end
	end

endmodule

FILE: sv/bst_res_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on bst_pkg.
module bst_res_fifo
	import bst_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  space,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	res_t            mem_q [RES_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// room for the worst case of two results from the next byte
	assign space     = (cnt_q <= CW'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + PW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push.count);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

FILE: sv/byte_stream_tokenizer.sv
`timescale 1ns / 1ps
// Byte stream tokenizer: one text byte per transfer in, one token result per transfer out.
// A result is registered in the queue as its completing byte is taken, then offered in order.
// Throughput: one byte per cycle while the queue has room (m_axis_tready high and at most
// one result per byte); a byte's two results leave one per transfer via a 4-entry queue.
// Reset (arst_n low, asynchronous): lexer returns to idle, offsets to zero, queue empties.
module byte_stream_tokenizer
	import bst_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length
	output logic [5:0]  m_axis_tuser,   // [3:0] token_kind, [5:4] error_code
	output logic        m_axis_tlast    // last_of_run
);

	logic  in_xfer;
	push_t push;
	res_t  res;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	bst_lexer #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_xfer),
		.char_byte  (s_axis_tdata),
		.end_of_text(s_axis_tlast),
		.push       (push)
	);

	bst_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space    (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

	assign m_axis_tdata = {res.length, res.start};
	assign m_axis_tuser = {res.err, res.kind};
	assign m_axis_tlast = res.last;

	a_push_only_on_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |-> push.count == 2'd0)
		else $error("results pushed without an input transfer");

	a_single_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd1 |-> push.r0.last)
		else $error("sole result of a byte not marked last");

	a_pair_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.r1.last && !push.r0.last)
		else $error("result pair has wrong last marking");

	a_stall_means_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty result queue");

endmodule
